/* rtl/core/tcd_pkg.sv */
// Shared types and constants for the TPKT/COTP receive deframer.
// No dependencies; used by the channel interfaces, the frame parser and the top level.
package tcd_pkg;

   localparam int unsigned COUNT_W = 23;
   localparam int unsigned LEN_W   = 16;
   localparam int unsigned FUNC_W  = 2;

   localparam logic [COUNT_W-1:0] LIMIT_MAX = 23'd4194304;

   localparam logic [7:0]       TPKT_VERSION  = 8'h03;
   localparam logic [7:0]       TPKT_RESERVED = 8'h00;
   localparam logic [7:0]       COTP_DT       = 8'h02;
   localparam logic [7:0]       COTP_DT_CODE  = 8'hf0;
   localparam logic [7:0]       COTP_EOT_MASK = 8'h80;
   localparam logic [7:0]       COTP_RSV_MASK = 8'h7f;
   localparam logic [LEN_W-1:0] HDR_BYTES     = 16'd7;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_BYTE    = 2'd0,
      FUNC_TIMEOUT = 2'd1,
      FUNC_OPEN    = 2'd2
   } func_type;

   typedef enum logic [2:0] {
      ST_DATA    = 3'd0,
      ST_BADHDR  = 3'd1,
      ST_SHORT   = 3'd2,
      ST_NOTDT   = 3'd3,
      ST_EMPTY   = 3'd4,
      ST_LONG    = 3'd5,
      ST_PARTIAL = 3'd6
   } status_type;

   // header byte expected next; HDR_BODY means payload
   typedef enum logic [2:0] {
      HDR_VER       = 3'd0,
      HDR_RSV       = 3'd1,
      HDR_LEN_HI    = 3'd2,
      HDR_LEN_LO    = 3'd3,
      HDR_COTP_TYPE = 3'd4,
      HDR_COTP_CODE = 3'd5,
      HDR_COTP_FLAG = 3'd6,
      HDR_BODY      = 3'd7
   } hdr_type;

   typedef struct packed {
      status_type         status;
      logic [7:0]         data_byte;
      logic               last_in_message;
      logic [COUNT_W-1:0] message_bytes;
   } rsp_item_type;

endpackage

/* rtl/core/tcd_channels.sv */
// Valid/ready channel interfaces for the deframer request and response streams.
// Depends on tcd_pkg for field widths.
interface tcd_req_if;
   import tcd_pkg::*;

   logic              valid;
   logic              ready;
   logic [FUNC_W-1:0] func;
   logic [7:0]        rx_byte;

   modport source (output valid, output func, output rx_byte, input ready);
   modport sink   (input valid, input func, input rx_byte, output ready);
endinterface

interface tcd_rsp_if;
   import tcd_pkg::*;

   logic               valid;
   logic               ready;
   logic [2:0]         status;
   logic [7:0]         data_byte;
   logic               last_in_message;
   logic [COUNT_W-1:0] message_bytes;

   modport source (output valid, output status, output data_byte, output last_in_message,
                   output message_bytes, input ready);
   modport sink   (input valid, input status, input data_byte, input last_in_message,
                   input message_bytes, output ready);
endinterface

/* rtl/core/tcd_frame_parser.sv */
// Frame state machine: header parse, segment checks and message byte count.
// Depends on tcd_pkg. Advances one transaction per cycle when step is high.
module tcd_frame_parser (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         step,
   input  logic [tcd_pkg::FUNC_W-1:0]   func,
   input  logic [7:0]                   rx_byte,
   input  logic [tcd_pkg::COUNT_W-1:0]  limit,
   output logic                         emit,
   output tcd_pkg::rsp_item_type        item
);
   import tcd_pkg::*;

   logic               open_ff,    open_in;
   hdr_type            hdr_ff,     hdr_in;
   logic [LEN_W-1:0]   frame_len_ff, frame_len_in;
   logic [LEN_W-1:0]   left_ff,    left_in;
   logic               bad_ff,     bad_in;
   logic               final_ff,   final_in;
   logic [COUNT_W-1:0] count_ff,   count_in;

   logic               fail;
   status_type         fail_code;
   logic [LEN_W-1:0]   len_full;
   logic [LEN_W-1:0]   seg_len;
   logic [COUNT_W:0]   seg_sum;
   logic [COUNT_W-1:0] count_inc;
   logic [LEN_W-1:0]   left_dec;

   assign len_full  = {frame_len_ff[LEN_W-1:8], rx_byte};
   assign seg_len   = frame_len_ff - HDR_BYTES;
   assign seg_sum   = {1'b0, count_ff} + {{(COUNT_W+1-LEN_W){1'b0}}, seg_len};
   assign count_inc = count_ff + {{(COUNT_W-1){1'b0}}, 1'b1};
   assign left_dec  = left_ff - {{(LEN_W-1){1'b0}}, 1'b1};

   always_comb begin
      open_in      = open_ff;
      hdr_in       = hdr_ff;
      frame_len_in = frame_len_ff;
      left_in      = left_ff;
      bad_in       = bad_ff;
      final_in     = final_ff;
      count_in     = count_ff;
      fail         = 1'b0;
      fail_code    = ST_PARTIAL;
      emit         = 1'b0;
      item         = '0;

      case (func)
         FUNC_OPEN: begin
            open_in      = 1'b1;
            hdr_in       = HDR_VER;
            frame_len_in = '0;
            left_in      = '0;
            bad_in       = 1'b0;
            final_in     = 1'b0;
            count_in     = '0;
         end
         FUNC_TIMEOUT: begin
            // mid-frame only; a message spanning segments survives at a boundary
            if (open_ff && (hdr_ff != HDR_VER)) begin
               fail      = 1'b1;
               fail_code = ST_PARTIAL;
            end
         end
         FUNC_BYTE: begin
            if (open_ff) begin
               case (hdr_ff)
                  HDR_VER: begin
                     bad_in = (rx_byte != TPKT_VERSION);
                     hdr_in = HDR_RSV;
                  end
                  HDR_RSV: begin
                     if (rx_byte != TPKT_RESERVED) bad_in = 1'b1;
                     hdr_in = HDR_LEN_HI;
                  end
                  HDR_LEN_HI: begin
                     frame_len_in = {rx_byte, 8'h00};
                     hdr_in       = HDR_LEN_LO;
                  end
                  HDR_LEN_LO: begin
                     frame_len_in = len_full;
                     if (len_full < HDR_BYTES) begin
                        fail      = 1'b1;
                        fail_code = ST_SHORT;
                     end else if (bad_ff) begin
                        fail      = 1'b1;
                        fail_code = ST_BADHDR;
                     end else begin
                        hdr_in = HDR_COTP_TYPE;
                     end
                  end
                  HDR_COTP_TYPE: begin
                     if (rx_byte != COTP_DT) bad_in = 1'b1;
                     hdr_in = HDR_COTP_CODE;
                  end
                  HDR_COTP_CODE: begin
                     if (rx_byte != COTP_DT_CODE) bad_in = 1'b1;
                     hdr_in = HDR_COTP_FLAG;
                  end
                  HDR_COTP_FLAG: begin
                     if (bad_ff || ((rx_byte & COTP_RSV_MASK) != 8'h00)) begin
                        fail      = 1'b1;
                        fail_code = ST_NOTDT;
                     end else if (seg_len == '0) begin
                        fail      = 1'b1;
                        fail_code = ST_EMPTY;
                     end else if (seg_sum > {1'b0, limit}) begin
                        fail      = 1'b1;
                        fail_code = ST_LONG;
                     end else begin
                        final_in = ((rx_byte & COTP_EOT_MASK) != 8'h00);
                        left_in  = seg_len;
                        hdr_in   = HDR_BODY;
                     end
                  end
                  HDR_BODY: begin
                     emit                 = 1'b1;
                     item.status          = ST_DATA;
                     item.data_byte       = rx_byte;
                     item.last_in_message = (left_dec == '0) && final_ff;
                     item.message_bytes   = count_inc;
                     count_in             = count_inc;
                     left_in              = left_dec;
                     if (left_dec == '0) begin
                        hdr_in       = HDR_VER;
                        frame_len_in = '0;
                        bad_in       = 1'b0;
                        final_in     = 1'b0;
                        if (final_ff) count_in = '0;
                     end
                  end
                  default: begin
                     hdr_in = HDR_VER;
                  end
               endcase
            end
         end
         default: begin
            // unknown function code: ignore
         end
      endcase

      // any fault drops the open message and closes the channel
      if (fail) begin
         emit               = 1'b1;
         item.status        = fail_code;
         item.message_bytes = count_ff;
         open_in            = 1'b0;
         hdr_in             = HDR_VER;
         frame_len_in       = '0;
         left_in            = '0;
         bad_in             = 1'b0;
         final_in           = 1'b0;
         count_in           = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         open_ff      <= 1'b0;
         hdr_ff       <= HDR_VER;
         frame_len_ff <= '0;
         left_ff      <= '0;
         bad_ff       <= 1'b0;
         final_ff     <= 1'b0;
         count_ff     <= '0;
      end else if (step) begin
         open_ff      <= open_in;
         hdr_ff       <= hdr_in;
         frame_len_ff <= frame_len_in;
         left_ff      <= left_in;
         bad_ff       <= bad_in;
         final_ff     <= final_in;
         count_ff     <= count_in;
      end
   end

endmodule

/* rtl/core/tpkt_cotp_receive_deframer.sv */
// Top level of the TPKT/COTP DT receive deframer: input register, parser, result register.
// Depends on tcd_pkg, tcd_req_if/tcd_rsp_if and tcd_frame_parser.
//
//   channel | dir | handshake         | payload
//   req_if  | in  | valid/ready       | func[1:0], rx_byte[7:0]
//   rsp_if  | out | valid/ready       | status[2:0], data_byte[7:0], last_in_message,
//           |     |                   | message_bytes[22:0]
//   csr     | in  | csr_wr_en         | csr_wr_data[22:0] (message byte limit)
//
// One transaction per cycle sustained unless rsp_if stalls; rsp_if.valid rises once an
// accepted transaction has passed the input register and then the result register.
// Reset is synchronous and closes the channel; the limit returns to 4194304.
// A stalled rsp_if backs up into the input register, then req_if.ready drops.
module tpkt_cotp_receive_deframer (
   input  logic                        clock,
   input  logic                        reset,
   tcd_req_if.sink                     req_if,
   tcd_rsp_if.source                   rsp_if,
   input  logic                        csr_wr_en,
   input  logic [tcd_pkg::COUNT_W-1:0] csr_wr_data
);
   import tcd_pkg::*;

   logic               in_valid_ff, in_valid_in;
   logic [FUNC_W-1:0]  in_func_ff;
   logic [7:0]         in_byte_ff;
   logic               out_valid_ff, out_valid_in;
   rsp_item_type       rsp_item_ff;
   logic [COUNT_W-1:0] limit_ff;

   logic               advance;
   logic               step;
   logic               take;
   logic               emit;
   rsp_item_type       item;

   assign advance      = !out_valid_ff || rsp_if.ready;
   assign step         = in_valid_ff && advance;
   assign req_if.ready = !in_valid_ff || advance;
   assign take         = req_if.valid && req_if.ready;
   assign in_valid_in  = take ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
   assign out_valid_in = advance ? (step && emit) : out_valid_ff;

   tcd_frame_parser u_parser (
      .clock   (clock),
      .reset   (reset),
      .step    (step),
      .func    (in_func_ff),
      .rx_byte (in_byte_ff),
      .limit   (limit_ff),
      .emit    (emit),
      .item    (item)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         limit_ff     <= LIMIT_MAX;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         // clip the limit at write time
         if (csr_wr_en) limit_ff <= (csr_wr_data > LIMIT_MAX) ? LIMIT_MAX : csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         in_func_ff <= req_if.func;
         in_byte_ff <= req_if.rx_byte;
      end
      if (advance) rsp_item_ff <= item;
   end

   assign rsp_if.valid           = out_valid_ff;
   assign rsp_if.status          = rsp_item_ff.status;
   assign rsp_if.data_byte       = rsp_item_ff.data_byte;
   assign rsp_if.last_in_message = rsp_item_ff.last_in_message;
   assign rsp_if.message_bytes   = rsp_item_ff.message_bytes;

   a_error_no_payload: assert property (@(posedge clock) disable iff (reset)
      (rsp_if.valid && (rsp_if.status != ST_DATA)) |->
         (!rsp_if.last_in_message && (rsp_if.data_byte == 8'h00)))
      else $error("error status carries payload");

   a_count_within_limit: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid |-> (rsp_if.message_bytes <= LIMIT_MAX))
      else $error("message byte count above limit");

   a_ready_only_on_stall: assert property (@(posedge clock) disable iff (reset)
      !req_if.ready |-> (in_valid_ff && out_valid_ff && !rsp_if.ready))
      else $error("request side stalled without output backpressure");

   a_data_counts_from_one: assert property (@(posedge clock) disable iff (reset)
      (rsp_if.valid && (rsp_if.status == ST_DATA)) |-> (rsp_if.message_bytes != '0))
      else $error("payload byte with zero message count");

endmodule

/* dv/tb.sv */
// Self-checking testbench for the TPKT/COTP DT receive deframer top level.
// Depends on tcd_pkg, tcd_req_if/tcd_rsp_if and tpkt_cotp_receive_deframer.
module tb;
   import tcd_pkg::*;

   localparam logic [1:0] FUNC_UNUSED = 2'd3;
   localparam int FAULT_NONE  = 0;
   localparam int FAULT_HDR   = 1;
   localparam int FAULT_CUT   = 2;
   localparam int CYCLE_LIMIT = 500000;
   localparam int DRAIN_LIMIT = 50000;
   localparam int HOLD_CYCLES = 400;

   typedef struct packed {
      logic [1:0] func;
      logic [7:0] rx_byte;
   } rx_item_type;

   logic clock;
   logic reset;
   logic csr_wr_en;
   logic [COUNT_W-1:0] csr_wr_data;

   tcd_req_if req_if ();
   tcd_rsp_if rsp_if ();

   tpkt_cotp_receive_deframer uut (
      .clock       (clock),
      .reset       (reset),
      .req_if      (req_if),
      .rsp_if      (rsp_if),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // deframer state as the block should hold it
   logic [COUNT_W-1:0] limit_reg = LIMIT_MAX;
   logic               link_open = 1'b0;
   hdr_type            hdr_pos   = HDR_VER;
   logic [LEN_W-1:0]   frame_len = '0;
   logic [LEN_W-1:0]   body_left = '0;
   logic               hdr_bad   = 1'b0;
   logic               seg_final = 1'b0;
   logic [COUNT_W-1:0] msg_count = '0;

   rx_item_type  rx_stream_q[$];
   rsp_item_type deframed_q[$];
   rx_item_type  nxt;
   rsp_item_type want;

   int  queued_total  = 0;
   int  error_count   = 0;
   int  cycle_count   = 0;
   int  gap_left      = 0;
   int  stall_left    = 0;
   int  hold_left     = 0;
   int  hold_requests = 0;
   int  hold_seen     = 0;
   bit  idling_on     = 1'b0;

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   function automatic void clear_link();
      hdr_pos   = HDR_VER;
      frame_len = '0;
      body_left = '0;
      hdr_bad   = 1'b0;
      seg_final = 1'b0;
      msg_count = '0;
   endfunction

   // report an error with the bytes being dropped, then close
   function automatic void close_with(input status_type st);
      rsp_item_type r;
      r = '0;
      r.status = st;
      r.message_bytes = msg_count;
      deframed_q.insert(deframed_q.size(), r);
      clear_link();
      link_open = 1'b0;
   endfunction

   function automatic void deframe_step(input logic [1:0] fn, input logic [7:0] b);
      rsp_item_type r;
      logic [31:0]  seg;
      logic [31:0]  lim;
      if (fn == FUNC_OPEN) begin
         clear_link();
         link_open = 1'b1;
      end else if (fn == FUNC_TIMEOUT) begin
         if (link_open && hdr_pos != HDR_VER)
            close_with(ST_PARTIAL);
      end else if (fn == FUNC_BYTE && link_open) begin
         case (hdr_pos)
            HDR_VER: begin
               hdr_bad = (b != TPKT_VERSION);
               hdr_pos = HDR_RSV;
            end
            HDR_RSV: begin
               if (b != TPKT_RESERVED)
                  hdr_bad = 1'b1;
               hdr_pos = HDR_LEN_HI;
            end
            HDR_LEN_HI: begin
               frame_len = {b, 8'h00};
               hdr_pos = HDR_LEN_LO;
            end
            HDR_LEN_LO: begin
               frame_len = frame_len | {8'h00, b};
               if (frame_len < HDR_BYTES)
                  close_with(ST_SHORT);
               else if (hdr_bad)
                  close_with(ST_BADHDR);
               else
                  hdr_pos = HDR_COTP_TYPE;
            end
            HDR_COTP_TYPE: begin
               // the same flag now tracks a bad COTP header
               if (b != COTP_DT)
                  hdr_bad = 1'b1;
               hdr_pos = HDR_COTP_CODE;
            end
            HDR_COTP_CODE: begin
               if (b != COTP_DT_CODE)
                  hdr_bad = 1'b1;
               hdr_pos = HDR_COTP_FLAG;
            end
            HDR_COTP_FLAG: begin
               seg = 32'(frame_len - HDR_BYTES);
               lim = (limit_reg > LIMIT_MAX) ? 32'(LIMIT_MAX) : 32'(limit_reg);
               if (hdr_bad || (b & COTP_RSV_MASK) != 8'h00)
                  close_with(ST_NOTDT);
               else if (seg == 0)
                  close_with(ST_EMPTY);
               else if (32'(msg_count) + seg > lim)
                  close_with(ST_LONG);
               else begin
                  seg_final = (b & COTP_EOT_MASK) != 8'h00;
                  body_left = seg[LEN_W-1:0];
                  hdr_pos = HDR_BODY;
               end
            end
            default: begin
               msg_count = msg_count + 1'b1;
               body_left = body_left - 1'b1;
               r = '0;
               r.status = ST_DATA;
               r.data_byte = b;
               r.last_in_message = (body_left == 0) && seg_final;
               r.message_bytes = msg_count;
               deframed_q.insert(deframed_q.size(), r);
               if (body_left == 0) begin
                  hdr_pos = HDR_VER;
                  frame_len = '0;
                  hdr_bad = 1'b0;
                  if (seg_final)
                     msg_count = '0;
                  seg_final = 1'b0;
               end
            end
         endcase
      end
   endfunction

   // driver: advance the stream on each accepted transaction
   always @(posedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
         req_if.func <= FUNC_BYTE;
         req_if.rx_byte <= 8'h00;
         gap_left = 0;
      end else begin
         if (req_if.valid && req_if.ready)
            deframe_step(req_if.func, req_if.rx_byte);
         if (!req_if.valid || req_if.ready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_if.valid <= 1'b0;
            end else if (rx_stream_q.size() > 0) begin
               nxt = rx_stream_q.pop_front();
               req_if.valid <= 1'b1;
               req_if.func <= nxt.func;
               req_if.rx_byte <= nxt.rx_byte;
               if (idling_on && $urandom_range(0, 9) == 0)
                  gap_left = $urandom_range(1, 15);
            end else begin
               req_if.valid <= 1'b0;
            end
         end
      end
   end

   // monitor: check each result transaction and pace ready
   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            if (deframed_q.size() == 0) begin
               $display("%0t: unexpected result status=%0d data=%02h last=%0b count=%0d", $time,
                        rsp_if.status, rsp_if.data_byte, rsp_if.last_in_message,
                        rsp_if.message_bytes);
               error_count++;
            end else begin
               want = deframed_q.pop_front();
               if (rsp_if.status !== want.status) begin
                  $display("%0t: status expected %0d got %0d", $time, want.status,
                           rsp_if.status);
                  error_count++;
               end
               if (rsp_if.data_byte !== want.data_byte) begin
                  $display("%0t: data_byte expected %02h got %02h", $time, want.data_byte,
                           rsp_if.data_byte);
                  error_count++;
               end
               if (rsp_if.last_in_message !== want.last_in_message) begin
                  $display("%0t: last_in_message expected %0b got %0b", $time,
                           want.last_in_message, rsp_if.last_in_message);
                  error_count++;
               end
               if (rsp_if.message_bytes !== want.message_bytes) begin
                  $display("%0t: message_bytes expected %0d got %0d", $time,
                           want.message_bytes, rsp_if.message_bytes);
                  error_count++;
               end
            end
         end
         if (hold_seen != hold_requests) begin
            hold_seen = hold_requests;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_if.ready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_if.ready <= 1'b0;
         end else if (idling_on && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(1, 15) - 1;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   task automatic queue_item(input logic [1:0] fn, input logic [7:0] b);
      rx_item_type it;
      it.func = fn;
      it.rx_byte = b;
      rx_stream_q.insert(rx_stream_q.size(), it);
      queued_total++;
   endtask

   // one TPKT/COTP DT segment; fill < 0 gives random payload
   task automatic queue_segment(input int len, input bit eot, input int fault, input int fill);
      logic [7:0]       hdr [0:6];
      logic [LEN_W-1:0] flen;
      int               cut;
      flen = LEN_W'(len + 7);
      hdr[0] = TPKT_VERSION;
      hdr[1] = TPKT_RESERVED;
      hdr[2] = flen[15:8];
      hdr[3] = flen[7:0];
      hdr[4] = COTP_DT;
      hdr[5] = COTP_DT_CODE;
      hdr[6] = eot ? COTP_EOT_MASK : 8'h00;
      cut = len + 7;
      if (fault == FAULT_HDR)
         hdr[$urandom_range(0, 6)] = 8'($urandom);
      else if (fault == FAULT_CUT)
         cut = $urandom_range(1, len + 6);
      for (int i = 0; i < cut; i++) begin
         if (i < 7)
            queue_item(FUNC_BYTE, hdr[i]);
         else
            queue_item(FUNC_BYTE, (fill < 0) ? 8'($urandom) : 8'(fill));
      end
      // drop the partial frame by deadline or by reopening
      if (fault == FAULT_CUT)
         queue_item($urandom_range(0, 1) ? FUNC_TIMEOUT : FUNC_OPEN, 8'($urandom));
   endtask

   task automatic queue_random_traffic(input int n_items, input int max_len);
      int target;
      int pick;
      int segs;
      int len;
      int fault;
      bit eot;
      target = queued_total + n_items;
      while (queued_total < target) begin
         pick = $urandom_range(0, 99);
         if (pick < 4)
            queue_item(FUNC_UNUSED, 8'($urandom));
         else if (pick < 9)
            queue_item(FUNC_TIMEOUT, 8'($urandom));
         else if (pick < 12)
            queue_item(FUNC_BYTE, 8'($urandom));
         else begin
            if ($urandom_range(0, 3) != 0)
               queue_item(FUNC_OPEN, 8'($urandom));
            segs = $urandom_range(1, 3);
            for (int s = 0; s < segs; s++) begin
               pick = $urandom_range(0, 19);
               len = (pick == 0) ? 0 : (pick == 1) ? $urandom_range(1, max_len)
                                                   : $urandom_range(1, 12);
               eot = (s == segs - 1) && ($urandom_range(0, 7) != 0);
               fault = ($urandom_range(0, 9) == 0) ? $urandom_range(FAULT_HDR, FAULT_CUT)
                                                   : FAULT_NONE;
               queue_segment(len, eot, fault, -1);
               if (fault != FAULT_NONE)
                  break;
            end
         end
      end
   endtask

   // hold until the stream and all results have drained, then settle the pipeline
   task automatic wait_quiet();
      int waited;
      waited = 0;
      do begin
         @(posedge clock);
         waited++;
      end while ((rx_stream_q.size() != 0 || req_if.valid || deframed_q.size() != 0)
                 && waited < DRAIN_LIMIT);
      repeat (8) @(posedge clock);
      if (deframed_q.size() != 0) begin
         $display("%0t: %0d expected results never arrived", $time, deframed_q.size());
         error_count++;
         deframed_q.delete();
      end
   endtask

   task automatic set_limit(input logic [COUNT_W-1:0] value);
      wait_quiet();
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      limit_reg = value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   initial begin
      reset = 1'b1;
      csr_wr_en = 1'b0;
      csr_wr_data = '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // one-byte EOT frame, deadline at a frame boundary, unused func
      queue_item(FUNC_OPEN, 8'h00);
      queue_segment(1, 1'b1, FAULT_NONE, 8'hff);
      queue_item(FUNC_TIMEOUT, 8'hff);
      queue_item(FUNC_UNUSED, 8'hff);
      // length below the header size
      queue_item(FUNC_BYTE, TPKT_VERSION);
      queue_item(FUNC_BYTE, TPKT_RESERVED);
      queue_item(FUNC_BYTE, 8'h00);
      queue_item(FUNC_BYTE, 8'h06);
      // bad reserved byte in the TPKT header
      queue_item(FUNC_OPEN, 8'h00);
      queue_item(FUNC_BYTE, TPKT_VERSION);
      queue_item(FUNC_BYTE, 8'h01);
      queue_item(FUNC_BYTE, 8'h00);
      queue_item(FUNC_BYTE, 8'h08);
      // deadline in mid-header
      queue_item(FUNC_OPEN, 8'h00);
      queue_item(FUNC_BYTE, TPKT_VERSION);
      queue_item(FUNC_TIMEOUT, 8'h00);
      // open a message, then lower the limit below what it holds
      queue_item(FUNC_OPEN, 8'h00);
      queue_segment(2, 1'b0, FAULT_NONE, 8'h00);
      set_limit(23'd1);
      queue_segment(1, 1'b1, FAULT_NONE, -1);

      idling_on = 1'b1;
      set_limit(23'h7fffff);
      queue_random_traffic(300, 60);
      set_limit(COUNT_W'($urandom_range(2, 48)));
      queue_random_traffic(300, 30);

      // long receiver hold-off with the sender streaming
      idling_on = 1'b0;
      set_limit(LIMIT_MAX);
      hold_requests++;
      queue_random_traffic(120, 40);

      idling_on = 1'b1;
      set_limit(COUNT_W'($urandom_range(100, 5000)));
      queue_random_traffic(400, 80);

      idling_on = 1'b0;
      set_limit(COUNT_W'($urandom_range(1, 64)));
      queue_random_traffic(300, 40);
      wait_quiet();

      if (error_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
